@@ hdl/psq_pkg.sv @@
// Package for the palette set/query converter: types, codes, default palette
// and the channel conversion functions shared by the lanes and the top level.
// No dependencies.
package psq_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int NUM_LANES   = 3;
    localparam int SLOT_W      = 4;
    localparam int CHAN_W      = 10;
    localparam int NIB_W       = 4;
    localparam int WORD_W      = 12;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CHAN_W-1:0]  VMAX          = 10'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MIN     = 5'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_DEFAULT = 5'd16;

    // v*3/200 as a multiply by 7866 / 2^19, exact for v up to 1000.
    localparam logic [22:0] NIB_RECIP = 23'd7866;
    localparam int          NIB_SHIFT = 19;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NIB_W-1:0]  nib_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic { KIND_SET = 1'b0, KIND_QUERY = 1'b1 } kind_t;
    typedef enum logic { MODE_ST = 1'b0, MODE_STE = 1'b1 } mode_t;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUM_COLORS   = 2'd0,
        CFG_SHIFTER_MODE = 2'd1
    } cfg_index_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    // What one channel lane hands to the merging stage.
    typedef struct packed {
        chan_t clamped;
        nib_t  nib;
        chan_t readback;
    } lane_res_t;

    typedef struct packed {
        logic                status;
        chan_t               red;
        chan_t               green;
        chan_t               blue;
        logic                hw_write;
        slot_t               hw_slot;
        logic [WORD_W-1:0]   hw_word;
    } result_t;

    function automatic slot_t slot_map(input slot_t i);
        slot_t s;
        case (i)
            4'd0:    s = 4'd0;
            4'd1:    s = 4'd15;
            4'd2:    s = 4'd1;
            4'd3:    s = 4'd2;
            4'd4:    s = 4'd4;
            4'd5:    s = 4'd6;
            4'd6:    s = 4'd3;
            4'd7:    s = 4'd5;
            4'd8:    s = 4'd7;
            4'd9:    s = 4'd8;
            4'd10:   s = 4'd9;
            4'd11:   s = 4'd10;
            4'd12:   s = 4'd12;
            4'd13:   s = 4'd14;
            4'd14:   s = 4'd11;
            default: s = 4'd13;
        endcase
        return s;
    endfunction

    function automatic rgb_t default_rgb(input slot_t i);
        rgb_t c;
        case (i)
            4'd0:    c = '{10'd1000, 10'd1000, 10'd1000};
            4'd1:    c = '{10'd0,    10'd0,    10'd0};
            4'd2:    c = '{10'd1000, 10'd0,    10'd0};
            4'd3:    c = '{10'd0,    10'd1000, 10'd0};
            4'd4:    c = '{10'd0,    10'd0,    10'd1000};
            4'd5:    c = '{10'd0,    10'd1000, 10'd1000};
            4'd6:    c = '{10'd1000, 10'd1000, 10'd0};
            4'd7:    c = '{10'd1000, 10'd0,    10'd1000};
            4'd8:    c = '{10'd700,  10'd700,  10'd700};
            4'd9:    c = '{10'd400,  10'd400,  10'd400};
            4'd10:   c = '{10'd1000, 10'd400,  10'd400};
            4'd11:   c = '{10'd400,  10'd1000, 10'd400};
            4'd12:   c = '{10'd400,  10'd400,  10'd1000};
            4'd13:   c = '{10'd400,  10'd1000, 10'd1000};
            4'd14:   c = '{10'd1000, 10'd1000, 10'd400};
            default: c = '{10'd1000, 10'd400,  10'd1000};
        endcase
        return c;
    endfunction

    // Scale to four bits, then move the lowest bit to the top.
    function automatic nib_t to_nibble(input chan_t v);
        logic [22:0] p;
        nib_t        c;
        p = 23'(v) * NIB_RECIP;
        c = p[NIB_SHIFT +: NIB_W];
        return {c[0], c[3:1]};
    endfunction

    // Packs a colour into its palette word, red in the top nibble.
    function automatic logic [WORD_W-1:0] rgb_word(input rgb_t c);
        return {to_nibble(c.r), to_nibble(c.g), to_nibble(c.b)};
    endfunction

    // (n & 7) * 1000 / 7
    function automatic chan_t st_back(input nib_t n);
        chan_t v;
        case (n[2:0])
            3'd0:    v = 10'd0;
            3'd1:    v = 10'd142;
            3'd2:    v = 10'd285;
            3'd3:    v = 10'd428;
            3'd4:    v = 10'd571;
            3'd5:    v = 10'd714;
            3'd6:    v = 10'd857;
            default: v = 10'd1000;
        endcase
        return v;
    endfunction

    // Undo the rotation, then c * 200 / 3.
    function automatic chan_t ste_back(input nib_t n);
        nib_t  c;
        chan_t v;
        c = {n[2:0], n[3]};
        case (c)
            4'd0:    v = 10'd0;
            4'd1:    v = 10'd66;
            4'd2:    v = 10'd133;
            4'd3:    v = 10'd200;
            4'd4:    v = 10'd266;
            4'd5:    v = 10'd333;
            4'd6:    v = 10'd400;
            4'd7:    v = 10'd466;
            4'd8:    v = 10'd533;
            4'd9:    v = 10'd600;
            4'd10:   v = 10'd666;
            4'd11:   v = 10'd733;
            4'd12:   v = 10'd800;
            4'd13:   v = 10'd866;
            4'd14:   v = 10'd933;
            default: v = 10'd1000;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/psq_if.sv @@
// Valid/ready channel interfaces for the palette set/query converter.
// Depends on psq_pkg for the field types.
interface psq_req_if
    import psq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] color_index;
    logic signed [15:0] red_in;
    logic signed [15:0] green_in;
    logic signed [15:0] blue_in;
    logic               want_realized;

    modport source (output valid, kind, color_index, red_in, green_in, blue_in,
                    want_realized, input ready);
    modport sink   (input valid, kind, color_index, red_in, green_in, blue_in,
                    want_realized, output ready);
endinterface

interface psq_rsp_if
    import psq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              status;
    chan_t             red_out;
    chan_t             green_out;
    chan_t             blue_out;
    logic              hw_write;
    slot_t             hw_slot;
    logic [WORD_W-1:0] hw_word;

    modport source (output valid, status, red_out, green_out, blue_out, hw_write,
                    hw_slot, hw_word, input ready);
    modport sink   (input valid, status, red_out, green_out, blue_out, hw_write,
                    hw_slot, hw_word, output ready);
endinterface

@@ hdl/psq_lane.sv @@
// One colour channel lane: clamps the input intensity, converts it to the
// palette nibble and converts a palette nibble back. Depends on psq_pkg.
module psq_lane
    import psq_pkg::*;
(
    input  logic signed [15:0] raw,
    input  nib_t               hw_nib,
    input  logic               mode,
    output lane_res_t          res
);

    chan_t clamped;

    always_comb
    begin
        if (raw[15])
        begin
            clamped = '0;
        end
        else if (raw > $signed({6'd0, VMAX}))
        begin
            clamped = VMAX;
        end
        else
        begin
            clamped = raw[CHAN_W-1:0];
        end
    end

    assign res.clamped  = clamped;
    assign res.nib      = to_nibble(clamped);
    assign res.readback = (mode == MODE_STE) ? ste_back(hw_nib) : st_back(hw_nib);

endmodule

@@ hdl/palette_set_query_converter.sv @@
// Top level of the palette set/query converter: configuration, palette
// registers, three channel lanes and the merging result register.
// Depends on psq_pkg, psq_if and psq_lane.
//
//  channel   dir  beat carries
//  req       in   kind, color_index, red_in, green_in, blue_in, want_realized
//  rsp       out  status, red/green/blue_out, hw_write, hw_slot, hw_word
//  cfg_*     in   write enable, register index, data (no read-back)
//
// Every request beat yields one response beat in the cycle after acceptance.
// A new request is taken every cycle while the response register is empty
// or being drained; the palette register read and the lane conversions
// are combinational. Reset loads the default palette and its converted
// words at once, so requests are taken as soon as reset is released.
// A stalled response holds its register and holds off further requests.
module palette_set_query_converter
    import psq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    psq_req_if.sink                req,
    psq_rsp_if.source              rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [COUNT_W-1:0] num_colors_reg;
    logic               shifter_mode_reg;
    rgb_t               req_colors_reg [NUM_SLOTS];
    logic [WORD_W-1:0]  hw_pal_reg     [NUM_SLOTS];
    logic               out_valid_reg;
    result_t            res_reg;
    result_t            res_next;

    logic [COUNT_W-1:0] eff_count;
    logic               idx_ok;
    slot_t              idx4;
    slot_t              slot;
    logic [WORD_W-1:0]  hw_rd;
    logic [WORD_W-1:0]  word;
    rgb_t               req_rd;
    logic               accept;
    logic               set_ok;
    logic signed [15:0] raw   [NUM_LANES];
    nib_t               nibs  [NUM_LANES];
    lane_res_t          lanes [NUM_LANES];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        if (num_colors_reg < COUNT_MIN)
        begin
            eff_count = COUNT_MIN;
        end
        else if (num_colors_reg > COUNT_MAX)
        begin
            eff_count = COUNT_MAX;
        end
        else
        begin
            eff_count = num_colors_reg;
        end
    end

    assign idx4   = req.color_index[SLOT_W-1:0];
    assign idx_ok = !req.color_index[15]
                    && ({1'b0, req.color_index[14:0]} < {11'd0, eff_count});
    // Logical entry one always lands on the last slot in use.
    assign slot   = (idx4 == 4'd1) ? SLOT_W'(eff_count - 5'd1) : slot_map(idx4);
    assign hw_rd  = hw_pal_reg[slot];
    assign req_rd = req_colors_reg[idx4];
    assign set_ok = accept && idx_ok && (req.kind == KIND_SET);

    assign raw[0]  = req.red_in;
    assign raw[1]  = req.green_in;
    assign raw[2]  = req.blue_in;
    assign nibs[0] = hw_rd[11:8];
    assign nibs[1] = hw_rd[7:4];
    assign nibs[2] = hw_rd[3:0];

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        psq_lane u_lane (
            .raw    (raw[l]),
            .hw_nib (nibs[l]),
            .mode   (shifter_mode_reg),
            .res    (lanes[l])
        );
    end

    assign word = {lanes[0].nib, lanes[1].nib, lanes[2].nib};

    // Merge the lane results into one response.
    always_comb
    begin
        res_next = '0;
        if (!idx_ok)
        begin
            res_next.status = 1'b1;
        end
        else if (req.kind == KIND_SET)
        begin
            res_next.hw_write = 1'b1;
            res_next.hw_slot  = slot;
            res_next.hw_word  = word;
        end
        else if (!req.want_realized)
        begin
            res_next.red   = req_rd.r;
            res_next.green = req_rd.g;
            res_next.blue  = req_rd.b;
        end
        else
        begin
            res_next.red   = lanes[0].readback;
            res_next.green = lanes[1].readback;
            res_next.blue  = lanes[2].readback;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_colors_reg   <= COUNT_DEFAULT;
            shifter_mode_reg <= MODE_STE;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                req_colors_reg[i] <= default_rgb(SLOT_W'(i));
                hw_pal_reg[slot_map(SLOT_W'(i))] <= rgb_word(default_rgb(SLOT_W'(i)));
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_COLORS:   num_colors_reg   <= cfg_data;
                    CFG_SHIFTER_MODE: shifter_mode_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (set_ok)
            begin
                req_colors_reg[idx4] <= '{lanes[0].clamped, lanes[1].clamped,
                                          lanes[2].clamped};
                hw_pal_reg[slot]     <= word;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = res_reg.status;
    assign rsp.red_out   = res_reg.red;
    assign rsp.green_out = res_reg.green;
    assign rsp.blue_out  = res_reg.blue;
    assign rsp.hw_write  = res_reg.hw_write;
    assign rsp.hw_slot   = res_reg.hw_slot;
    assign rsp.hw_word   = res_reg.hw_word;

    // A palette write is reported only for a good index.
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hw_write |-> !rsp.status)
        else $error("palette write reported with an index error");

    // An index error carries no colour and no write.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> (rsp.red_out == '0) && (rsp.green_out == '0)
            && (rsp.blue_out == '0) && !rsp.hw_write)
        else $error("index error beat carries data");

    // An accepted set leaves its word in the palette slot it reports.
    a_set_lands: assert property (@(posedge clk) disable iff (!rst_n)
        set_ok |=> hw_pal_reg[$past(slot)] == $past(word))
        else $error("palette slot not updated by set");

    // Every accepted request shows up as a response in the next cycle.
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid && (rsp.hw_write == $past(set_ok)))
        else $error("response missing after accepted request");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the palette set/query converter: drives request beats with bursts
// and gaps, stalls the response side, and checks every response against a palette predictor.
// Depends on psq_pkg, psq_if and palette_set_query_converter.

typedef struct packed {
    psq_pkg::kind_t     kind;
    logic signed [15:0] idx;
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic               want_realized;
} palette_req_t;

class palette_scoreboard;
    psq_pkg::rgb_t     requested [16];
    logic [11:0]       shifter_words [16];
    logic [4:0]        num_colors;
    psq_pkg::mode_t    readback_mode;
    bit [3:0]          slot_order [16];
    psq_pkg::result_t  awaited [$];
    int                failures;

    function new();
        int unsigned factory [16][3];
        factory = '{'{1000, 1000, 1000}, '{0, 0, 0}, '{1000, 0, 0}, '{0, 1000, 0},
                    '{0, 0, 1000}, '{0, 1000, 1000}, '{1000, 1000, 0}, '{1000, 0, 1000},
                    '{700, 700, 700}, '{400, 400, 400}, '{1000, 400, 400},
                    '{400, 1000, 400}, '{400, 400, 1000}, '{400, 1000, 1000},
                    '{1000, 1000, 400}, '{1000, 400, 1000}};
        slot_order = '{0, 15, 1, 2, 4, 6, 3, 5, 7, 8, 9, 10, 12, 14, 11, 13};
        num_colors = 5'd16;
        readback_mode = psq_pkg::MODE_STE;
        failures = 0;
        foreach (shifter_words[i])
            shifter_words[i] = '0;
        for (int i = 0; i < 16; i++)
        begin
            requested[i].r = psq_pkg::chan_t'(factory[i][0]);
            requested[i].g = psq_pkg::chan_t'(factory[i][1]);
            requested[i].b = psq_pkg::chan_t'(factory[i][2]);
            shifter_words[slot_for(i)] = pack_word(requested[i]);
        end
    endfunction

    function int unsigned colour_count();
        int unsigned n;
        n = num_colors;
        if (n < 2)
            n = 2;
        if (n > 16)
            n = 16;
        return n;
    endfunction

    // Logical entry 1 always lands on the last slot in use.
    function bit [3:0] slot_for(int unsigned idx);
        if (idx == 1)
            return 4'(colour_count() - 1);
        return slot_order[idx & 15];
    endfunction

    function bit [3:0] scale_to_nibble(int unsigned v);
        bit [3:0] c;
        c = 4'(v * 3 / 200);
        return {c[0], c[3:1]};
    endfunction

    function logic [11:0] pack_word(psq_pkg::rgb_t c);
        return {scale_to_nibble(c.r), scale_to_nibble(c.g), scale_to_nibble(c.b)};
    endfunction

    function psq_pkg::chan_t st_level(bit [3:0] n);
        return psq_pkg::chan_t'(int'(n[2:0]) * 1000 / 7);
    endfunction

    function psq_pkg::chan_t ste_level(bit [3:0] n);
        bit [3:0] c;
        c = {n[2:0], n[3]};
        return psq_pkg::chan_t'(int'(c) * 200 / 3);
    endfunction

    function psq_pkg::chan_t clamp_level(logic signed [15:0] v);
        int s;
        s = v;
        if (s < 0)
            return '0;
        if (s > 1000)
            return psq_pkg::chan_t'(1000);
        return psq_pkg::chan_t'(s);
    endfunction

    function void write_register(logic [1:0] index, logic [4:0] data);
        if (index == psq_pkg::CFG_NUM_COLORS)
            num_colors = data;
        else if (index == psq_pkg::CFG_SHIFTER_MODE)
            readback_mode = psq_pkg::mode_t'(data[0]);
    endfunction

    function void note_request(palette_req_t q);
        psq_pkg::result_t e;
        int               idx;
        logic [11:0]      w;
        bit [3:0]         s;
        e = '0;
        idx = q.idx;
        if (idx < 0 || idx >= int'(colour_count()))
            e.status = 1'b1;
        else if (q.kind == psq_pkg::KIND_SET)
        begin
            requested[idx].r = clamp_level(q.red);
            requested[idx].g = clamp_level(q.green);
            requested[idx].b = clamp_level(q.blue);
            s = slot_for(idx);
            w = pack_word(requested[idx]);
            shifter_words[s] = w;
            e.hw_write = 1'b1;
            e.hw_slot = s;
            e.hw_word = w;
        end
        else if (!q.want_realized)
        begin
            e.red = requested[idx].r;
            e.green = requested[idx].g;
            e.blue = requested[idx].b;
        end
        else
        begin
            w = shifter_words[slot_for(idx)];
            if (readback_mode == psq_pkg::MODE_STE)
            begin
                e.red = ste_level(w[11:8]);
                e.green = ste_level(w[7:4]);
                e.blue = ste_level(w[3:0]);
            end
            else
            begin
                e.red = st_level(w[11:8]);
                e.green = st_level(w[7:4]);
                e.blue = st_level(w[3:0]);
            end
        end
        awaited.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
        if (want != seen)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            failures++;
        end
    endfunction

    function void check_response(psq_pkg::result_t got);
        psq_pkg::result_t e;
        if (awaited.size() == 0)
        begin
            $error("response beat arrived with no request outstanding");
            failures++;
            return;
        end
        e = awaited.pop_front();
        compare_field("status", e.status, got.status);
        compare_field("red_out", e.red, got.red);
        compare_field("green_out", e.green, got.green);
        compare_field("blue_out", e.blue, got.blue);
        compare_field("hw_write", e.hw_write, got.hw_write);
        compare_field("hw_slot", e.hw_slot, got.hw_slot);
        compare_field("hw_word", e.hw_word, got.hw_word);
    endfunction
endclass

module tb_top;
    import psq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    // Register indices the block does not decode; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    psq_req_if req_ch ();
    psq_rsp_if rsp_ch ();

    palette_scoreboard sb = new();

    int burst_left;
    int run_left;
    int stall_style;
    int idle_cycles;
    int phase_count;
    int phase_mode;

    palette_set_query_converter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic palette_req_t make_request(kind_t k, int idx, int r, int g, int b,
                                                  bit realized);
        palette_req_t q;
        q.kind = k;
        q.idx = 16'(idx);
        q.red = 16'(r);
        q.green = 16'(g);
        q.blue = 16'(b);
        q.want_realized = realized;
        return q;
    endfunction

    function automatic int random_level();
        int pick;
        int edges [8];
        edges = '{-1, 0, 1, 999, 1000, 1001, -32768, 32767};
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        if (pick == 1)
            return edges[$urandom_range(0, 7)];
        return $urandom_range(0, 1000);
    endfunction

    function automatic palette_req_t random_request();
        int n;
        int idx;
        n = sb.colour_count();
        case ($urandom_range(0, 9))
            0: idx = int'($urandom_range(0, 65535)) - 32768;
            1: idx = -int'($urandom_range(1, 4));
            2: idx = n + $urandom_range(0, 2);
            3: idx = 1;
            default: idx = $urandom_range(0, n - 1);
        endcase
        return make_request(kind_t'($urandom_range(0, 1)), idx, random_level(),
                            random_level(), random_level(), 1'($urandom_range(0, 1)));
    endfunction

    // Entered just after a falling edge; leaves just after a falling edge at which
    // valid has not yet been assigned.
    task automatic offer(palette_req_t q);
        req_ch.valid <= 1'b1;
        req_ch.kind <= q.kind;
        req_ch.color_index <= q.idx;
        req_ch.red_in <= q.red;
        req_ch.green_in <= q.green;
        req_ch.blue_in <= q.blue;
        req_ch.want_realized <= q.want_realized;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(q);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_register(index, data);
        @(negedge clk);
    endtask

    // Receiver: runs of always-ready, random, long stalls and alternating beats.
    initial
    begin
        rsp_ch.ready = 1'b0;
        run_left = 0;
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                run_left = $urandom_range(8, 60);
            end
            run_left--;
            case (stall_style)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= (run_left == 0);
                default: rsp_ch.ready <= run_left[0];
            endcase
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status = rsp_ch.status;
            got.red = rsp_ch.red_out;
            got.green = rsp_ch.green_out;
            got.blue = rsp_ch.blue_out;
            got.hw_write = rsp_ch.hw_write;
            got.hw_slot = rsp_ch.hw_slot;
            got.hw_word = rsp_ch.hw_word;
            sb.check_response(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL palette_set_query_converter");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_SET;
        req_ch.color_index = '0;
        req_ch.red_in = '0;
        req_ch.green_in = '0;
        req_ch.blue_in = '0;
        req_ch.want_realized = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset palette, index range edges, clamping and the entry-1 remap.
        offer(make_request(KIND_QUERY, 0, 0, 0, 0, 1'b0));
        offer(make_request(KIND_QUERY, 0, 0, 0, 0, 1'b1));
        offer(make_request(KIND_QUERY, 1, 0, 0, 0, 1'b1));
        offer(make_request(KIND_QUERY, 15, 0, 0, 0, 1'b0));
        offer(make_request(KIND_QUERY, 15, 0, 0, 0, 1'b1));
        offer(make_request(KIND_QUERY, -32768, 0, 0, 0, 1'b0));
        offer(make_request(KIND_QUERY, 32767, 0, 0, 0, 1'b1));
        offer(make_request(KIND_QUERY, 16, 0, 0, 0, 1'b0));
        offer(make_request(KIND_QUERY, -1, 0, 0, 0, 1'b1));
        offer(make_request(KIND_SET, -1, 500, 500, 500, 1'b0));
        offer(make_request(KIND_SET, 16, 500, 500, 500, 1'b1));
        offer(make_request(KIND_SET, 0, 32767, -32768, 1000, 1'b0));
        offer(make_request(KIND_QUERY, 0, 0, 0, 0, 1'b0));
        offer(make_request(KIND_QUERY, 0, 0, 0, 0, 1'b1));
        offer(make_request(KIND_SET, 1, 1001, -1, 67, 1'b0));
        offer(make_request(KIND_QUERY, 1, 0, 0, 0, 1'b1));
        offer(make_request(KIND_SET, 15, 133, 134, 999, 1'b0));
        offer(make_request(KIND_QUERY, 15, 0, 0, 0, 1'b1));
        offer(make_request(KIND_QUERY, 1, 0, 0, 0, 1'b1));
        offer(make_request(KIND_QUERY, 1, 0, 0, 0, 1'b0));
        offer(make_request(KIND_SET, 7, 0, 1, 66, 1'b1));
        offer(make_request(KIND_QUERY, 7, 0, 0, 0, 1'b1));
        drain();

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: phase_count = 2;
                1: phase_count = 0;
                2: phase_count = 31;
                3: phase_count = 1;
                4: phase_count = 17;
                5: phase_count = 16;
                default: phase_count = $urandom_range(0, 31);
            endcase
            phase_mode = (p < 6) ? (p % 2 == 0 ? MODE_ST : MODE_STE) : $urandom_range(0, 1);
            write_config(CFG_NUM_COLORS, CFG_DATA_W'(phase_count));
            if (p % 3 == 1)
                write_config(p[1] ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO,
                             CFG_DATA_W'($urandom_range(0, 31)));
            write_config(CFG_SHIFTER_MODE, {4'($urandom_range(0, 15)), phase_mode[0]});
            repeat (120) offer(random_request());
            drain();
        end

        if (sb.failures == 0)
            $display("PASS palette_set_query_converter");
        else
            $display("FAIL palette_set_query_converter");
        $finish;
    end
endmodule
